FILE: hw/rtl/ztt_pkg.sv
// Shared types, constants and helpers of the Zobrist transposition table.
package ztt_pkg;

  localparam int ZTT_TABLE_ENTRIES = 4096;
  localparam int KEY_SLOTS         = 768;
  localparam int KEY_ADDR_W        = 10;
  localparam int HASH_W            = 64;
  localparam int RES_FIFO_DEPTH    = 16;
  localparam int RES_PTR_W         = 4;

  localparam logic [7:0] EMPTY_CHAR  = 8'h2E;  // '.'
  localparam logic [9:0] PIECE_CODES = 10'd12;

  typedef enum logic {
    KIND_KEY    = 1'b0,
    KIND_SQUARE = 1'b1
  } kind_t;

  typedef enum logic {
    OP_QUERY = 1'b0,
    OP_STORE = 1'b1
  } op_t;

  typedef struct packed {
    logic       ok;
    logic [3:0] code;
  } piece_t;

  // Per-board data that travels alongside the hash.
  typedef struct packed {
    logic               op;
    logic [7:0]         depth;
    logic signed [15:0] eval;
    logic               bad;
  } meta_t;

  typedef struct packed {
    logic [HASH_W-1:0]  hash;
    logic [7:0]         depth;
    logic signed [15:0] eval;
  } entry_t;

  typedef struct packed {
    logic               hit;
    logic [HASH_W-1:0]  hash;
    logic [7:0]         depth;
    logic signed [15:0] eval;
    logic               bad;
  } result_t;

  // Lower-case pieces take the first six codes, the upper-case ones the next six.
  function automatic piece_t piece_code(input logic [7:0] ch);
    piece_t p;
    p.ok = 1'b1;
    unique case (ch)
      8'h70:   p.code = 4'd0;   // p
      8'h72:   p.code = 4'd1;   // r
      8'h6E:   p.code = 4'd2;   // n
      8'h62:   p.code = 4'd3;   // b
      8'h71:   p.code = 4'd4;   // q
      8'h6B:   p.code = 4'd5;   // k
      8'h50:   p.code = 4'd6;   // P
      8'h52:   p.code = 4'd7;   // R
      8'h4E:   p.code = 4'd8;   // N
      8'h42:   p.code = 4'd9;   // B
      8'h51:   p.code = 4'd10;  // Q
      8'h4B:   p.code = 4'd11;  // K
      default: begin
        p.ok   = 1'b0;
        p.code = 4'd0;
      end
    endcase
    return p;
  endfunction

endpackage

FILE: hw/rtl/ztt_in_if.sv
// Input channel: key loads and board squares.
interface ztt_in_if;
  logic               valid;
  logic               ready;
  logic               kind;
  logic [9:0]         key_index;
  logic [63:0]        key_value;
  logic [5:0]         square_index;
  logic [7:0]         square_char;
  logic               last_square;
  logic               operation;
  logic [7:0]         depth;
  logic signed [15:0] eval;

  modport source (
    output valid, kind, key_index, key_value, square_index, square_char,
           last_square, operation, depth, eval,
    input  ready
  );
  modport sink (
    input  valid, kind, key_index, key_value, square_index, square_char,
           last_square, operation, depth, eval,
    output ready
  );
endinterface

FILE: hw/rtl/ztt_out_if.sv
// Output channel: one lookup result per board.
interface ztt_out_if;
  logic               valid;
  logic               ready;
  logic               hit;
  logic [63:0]        entry_hash;
  logic [7:0]         entry_depth;
  logic signed [15:0] entry_eval;
  logic               bad_square;

  modport source (
    output valid, hit, entry_hash, entry_depth, entry_eval, bad_square,
    input  ready
  );
  modport sink (
    input  valid, hit, entry_hash, entry_depth, entry_eval, bad_square,
    output ready
  );
endinterface

FILE: hw/rtl/ztt_hash_mod.sv
// Reduction of the board hash modulo the table size over four register stages.
module ztt_hash_mod #(
  parameter int TABLE_ENTRIES = ztt_pkg::ZTT_TABLE_ENTRIES,
  parameter int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  input  logic [ztt_pkg::HASH_W-1:0]  in_hash,
  input  ztt_pkg::meta_t              in_meta,
  output logic                        out_valid,
  output logic [ztt_pkg::HASH_W-1:0]  out_hash,
  output logic [IDX_W-1:0]            out_idx,
  output ztt_pkg::meta_t              out_meta
);

  // Eight bytes, each below 2^8, times weights below 2^IDX_W.
  localparam int SUM_W  = IDX_W + 11;
  localparam int PROD_W = 2 * SUM_W;
  localparam logic [IDX_W:0] MODULUS = (IDX_W + 1)'(TABLE_ENTRIES);
  // floor(2^SUM_W / TABLE_ENTRIES): the quotient it gives is exact or one short
  localparam logic [SUM_W:0] RECIP =
    (SUM_W + 1)'((64'd1 << SUM_W) / 64'(TABLE_ENTRIES));

  // Weight of hash byte i: 2^(8i) mod TABLE_ENTRIES.
  function automatic logic [7:0][IDX_W:0] byte_weights();
    logic [7:0][IDX_W:0] w;
    logic [63:0]         p;
    p = 64'd1 % 64'(TABLE_ENTRIES);
    for (int i = 0; i < 8; i++) begin
      w[i] = (IDX_W + 1)'(p);
      p    = (p << 8) % 64'(TABLE_ENTRIES);
    end
    return w;
  endfunction

  localparam logic [7:0][IDX_W:0] WEIGHTS = byte_weights();

  logic                       v0;
  logic                       v1;
  logic                       v2;
  logic                       v3;
  logic [ztt_pkg::HASH_W-1:0] h0;
  logic [ztt_pkg::HASH_W-1:0] h1;
  logic [ztt_pkg::HASH_W-1:0] h2;
  logic [ztt_pkg::HASH_W-1:0] h3;
  ztt_pkg::meta_t             m0;
  ztt_pkg::meta_t             m1;
  ztt_pkg::meta_t             m2;
  ztt_pkg::meta_t             m3;
  logic [SUM_W-1:0]           sum_next;
  logic [SUM_W-1:0]           sum1;
  logic [SUM_W-1:0]           sum2;
  logic [PROD_W-1:0]          prod;
  logic [SUM_W-1:0]           quot2;
  logic [SUM_W-1:0]           rem_wide;
  logic [IDX_W:0]             rem_low;
  logic [IDX_W:0]             rem_next;
  logic [IDX_W-1:0]           idx3;

  // weighted byte sum keeps the residue of the hash
  always_comb begin
    sum_next = '0;
    for (int i = 0; i < 8; i++) begin
      sum_next = sum_next + SUM_W'(h0[8*i +: 8]) * SUM_W'(WEIGHTS[i]);
    end
  end

  assign prod     = PROD_W'(sum1) * PROD_W'(RECIP);
  // remainder lands in [0, 2 * TABLE_ENTRIES); one subtract finishes it
  assign rem_wide = sum2 - quot2 * SUM_W'(TABLE_ENTRIES);
  assign rem_low  = rem_wide[IDX_W:0];
  assign rem_next = (rem_low >= MODULUS) ? rem_low - MODULUS : rem_low;

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      v0 <= in_valid;
      v1 <= v0;
      v2 <= v1;
      v3 <= v2;
    end
    h0    <= in_hash;
    h1    <= h0;
    h2    <= h1;
    h3    <= h2;
    m0    <= in_meta;
    m1    <= m0;
    m2    <= m1;
    m3    <= m2;
    sum1  <= sum_next;
    sum2  <= sum1;
    quot2 <= prod[SUM_W +: SUM_W];
    idx3  <= rem_next[IDX_W-1:0];
  end

  assign out_valid = v3;
  assign out_hash  = h3;
  assign out_idx   = idx3;
  assign out_meta  = m3;

endmodule

FILE: hw/rtl/zobrist_transposition_table.sv
// Zobrist transposition table: square-serial board hashing with a direct-mapped lookup.
//
// One transaction is taken every cycle while ready is high, whether it loads
// a key or carries a board square. A square reads its key from the 768-entry
// key memory at acceptance and XORs it into the running hash in the next cycle,
// so while ready stays high boards stream at one square per cycle with no gaps
// between them. On the last square the finished hash enters a four-stage unit
// (input register, weighted byte sum, reciprocal quotient, final correction)
// that forms hash mod TABLE_ENTRIES; the table memory is then read or written
// and the hit compare happens in the next cycle. Each result is queued in a
// 16-deep result FIFO, so the block keeps accepting while results wait; apart
// from the clearing pass, the input stalls only when sixteen results are in
// flight or queued. After reset a clearing pass zeros the table, one entry a
// cycle; no transaction is accepted until it completes. Key slots that were
// never loaded read as arbitrary data.
module zobrist_transposition_table #(
  parameter int TABLE_ENTRIES = ztt_pkg::ZTT_TABLE_ENTRIES
) (
  input  logic     clk,
  input  logic     rst,
  ztt_in_if.sink   items,
  ztt_out_if.source results
);

  localparam int IDX_W  = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int CNT_W  = IDX_W + 1;
  localparam logic [CNT_W-1:0] CLR_END = CNT_W'(TABLE_ENTRIES);
  localparam int FD     = ztt_pkg::RES_FIFO_DEPTH;
  localparam int PW     = ztt_pkg::RES_PTR_W;
  localparam logic [PW:0] FIFO_FULL = (PW + 1)'(FD);

  // ---- clearing pass after reset ----
  logic [CNT_W-1:0] clr_cnt;
  logic             clearing;
  assign clearing = (clr_cnt != CLR_END);

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt <= '0;
    end else if (clearing) begin
      clr_cnt <= clr_cnt + CNT_W'(1);
    end
  end

  // ---- input acceptance ----
  logic [PW:0] reserved;   // results in the pipe plus those in the FIFO
  logic        in_take;
  logic        is_square;
  logic        res_launch;
  logic        res_pop;

  assign items.ready = !clearing && (reserved < FIFO_FULL);
  assign in_take     = items.valid && items.ready;
  assign is_square   = (items.kind == ztt_pkg::KIND_SQUARE);
  assign res_launch  = in_take && is_square && items.last_square;

  always_ff @(posedge clk) begin
    if (rst) begin
      reserved <= '0;
    end else begin
      reserved <= reserved + (PW + 1)'(res_launch) - (PW + 1)'(res_pop);
    end
  end

  // ---- key memory: written by key transactions, read by squares ----
  ztt_pkg::piece_t                  piece;
  logic [ztt_pkg::KEY_ADDR_W-1:0]   key_addr;
  logic [ztt_pkg::HASH_W-1:0]       key_mem [ztt_pkg::KEY_SLOTS];
  logic [ztt_pkg::HASH_W-1:0]       key_rd;

  assign piece    = ztt_pkg::piece_code(items.square_char);
  assign key_addr = ztt_pkg::KEY_ADDR_W'(items.square_index) * ztt_pkg::PIECE_CODES
                  + ztt_pkg::KEY_ADDR_W'(piece.code);

  always_ff @(posedge clk) begin
    if (in_take && !is_square &&
        (items.key_index < ztt_pkg::KEY_ADDR_W'(ztt_pkg::KEY_SLOTS))) begin
      key_mem[items.key_index] <= items.key_value;
    end
    key_rd <= key_mem[key_addr];
  end

  // ---- hash accumulation stage ----
  logic                       s1_v;
  logic                       s1_piece;
  logic                       s1_bad;
  logic                       s1_last;
  ztt_pkg::meta_t             s1_meta;
  logic [ztt_pkg::HASH_W-1:0] running_hash;
  logic                       bad_flag;
  logic [ztt_pkg::HASH_W-1:0] hash_next;
  logic                       bad_next;
  logic                       board_done;
  ztt_pkg::meta_t             launch_meta;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
    end else begin
      s1_v <= in_take && is_square;
    end
    // '.' squares are neither pieces nor errors
    s1_piece      <= piece.ok;
    s1_bad        <= !piece.ok && (items.square_char != ztt_pkg::EMPTY_CHAR);
    s1_last       <= items.last_square;
    s1_meta.op    <= items.operation;
    s1_meta.depth <= items.depth;
    s1_meta.eval  <= items.eval;
    s1_meta.bad   <= 1'b0;
  end

  assign hash_next  = running_hash ^ (s1_piece ? key_rd : '0);
  assign bad_next   = bad_flag | s1_bad;
  assign board_done = s1_v && s1_last;

  always_comb begin
    launch_meta     = s1_meta;
    launch_meta.bad = bad_next;
  end

  // board end restores the empty-board state for the next board
  always_ff @(posedge clk) begin
    if (rst) begin
      running_hash <= '0;
      bad_flag     <= 1'b0;
    end else if (board_done) begin
      running_hash <= '0;
      bad_flag     <= 1'b0;
    end else if (s1_v) begin
      running_hash <= hash_next;
      bad_flag     <= bad_next;
    end
  end

  // ---- index reduction ----
  logic                       m_v;
  logic [ztt_pkg::HASH_W-1:0] m_hash;
  logic [IDX_W-1:0]           m_idx;
  ztt_pkg::meta_t             m_meta;

  ztt_hash_mod #(
    .TABLE_ENTRIES (TABLE_ENTRIES),
    .IDX_W         (IDX_W)
  ) u_mod (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (board_done),
    .in_hash   (hash_next),
    .in_meta   (launch_meta),
    .out_valid (m_v),
    .out_hash  (m_hash),
    .out_idx   (m_idx),
    .out_meta  (m_meta)
  );

  // ---- table access: one read or one write per board ----
  ztt_pkg::entry_t            tbl_mem [TABLE_ENTRIES];
  ztt_pkg::entry_t            tbl_rd;
  ztt_pkg::entry_t            tbl_wr;
  logic                       t_v;
  logic [ztt_pkg::HASH_W-1:0] t_hash;
  ztt_pkg::meta_t             t_meta;

  always_comb begin
    tbl_wr.hash  = m_hash;
    tbl_wr.depth = m_meta.depth;
    tbl_wr.eval  = m_meta.eval;
  end

  always_ff @(posedge clk) begin
    if (clearing) begin
      tbl_mem[clr_cnt[IDX_W-1:0]] <= '0;
    end else if (m_v && (m_meta.op == ztt_pkg::OP_STORE)) begin
      tbl_mem[m_idx] <= tbl_wr;
    end
    tbl_rd <= tbl_mem[m_idx];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      t_v <= 1'b0;
    end else begin
      t_v <= m_v;
    end
    t_hash <= m_hash;
    t_meta <= m_meta;
  end

  // stores report a miss with zero fields
  ztt_pkg::result_t res;
  logic             res_hit;

  assign res_hit = (t_meta.op == ztt_pkg::OP_QUERY) && (tbl_rd.hash == t_hash);

  always_comb begin
    res.hit   = res_hit;
    res.hash  = res_hit ? tbl_rd.hash  : '0;
    res.depth = res_hit ? tbl_rd.depth : '0;
    res.eval  = res_hit ? tbl_rd.eval  : '0;
    res.bad   = t_meta.bad;
  end

  // ---- result FIFO ----
  ztt_pkg::result_t fifo [FD];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic [PW:0]      fifo_cnt;
  ztt_pkg::result_t head;

  assign res_pop = results.valid && results.ready;

  always_ff @(posedge clk) begin
    if (t_v) begin
      fifo[wr_ptr] <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr   <= '0;
      rd_ptr   <= '0;
      fifo_cnt <= '0;
    end else begin
      if (t_v) wr_ptr <= wr_ptr + PW'(1);
      if (res_pop) rd_ptr <= rd_ptr + PW'(1);
      fifo_cnt <= fifo_cnt + (PW + 1)'(t_v) - (PW + 1)'(res_pop);
    end
  end

  assign head               = fifo[rd_ptr];
  assign results.valid      = (fifo_cnt != '0);
  assign results.hit        = head.hit;
  assign results.entry_hash = head.hash;
  assign results.entry_depth = head.depth;
  assign results.entry_eval = head.eval;
  assign results.bad_square = head.bad;

endmodule
